@@ rtl/core/lenient_utf8_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder assertion macros
// Property wrappers shared by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef LENIENT_UTF8_DECODER_ASSERT_SVH
`define LENIENT_UTF8_DECODER_ASSERT_SVH

// clocked property, off while reset is asserted
`define LUD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked through reset as well
`define LUD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lud_pkg.sv @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder package
// Shared types, lead byte thresholds and decode helpers.
// ----------------------------------------------------------------------------
package lud_pkg;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;

  typedef struct packed {
    logic [2:0][7:0] held_bytes;
    logic [1:0]      held_count;
    logic [2:0]      seq_len;
  } lud_state_t;

  typedef struct packed {
    logic [1:0]       count;
    logic             last;
    logic [2:0][20:0] cps;
  } lud_res_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b < LEAD2) return 3'd1;
    if (b < LEAD3) return 3'd2;
    if (b < LEAD4) return 3'd3;
    return 3'd4;
  endfunction

  function automatic logic [20:0] decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] len);
    logic [20:0] v;
    case (len)
      3'd2: v = {10'd0, b0[4:0], b1[5:0]};
      3'd3: v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4: v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: v = {13'd0, b0};
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/lud_decode.sv @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder step logic
// Combines the held bytes with a new byte and yields up to three code points
// plus the next sequence state.
// ----------------------------------------------------------------------------
module lud_decode (
  input  lud_pkg::lud_state_t st,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output lud_pkg::lud_state_t st_nxt,
  output lud_pkg::lud_res_t   res
);

  logic [3:0][7:0] bytes;
  logic [2:0]      n;
  logic [2:0]      pos;
  logic [1:0]      cnt;
  logic [2:0]      l;
  logic [2:0]      new_len;
  logic            emit;

  always_comb begin
    bytes = '0;
    for (int k = 0; k < 3; k++) begin
      bytes[k] = st.held_bytes[k];
    end
    bytes[st.held_count] = text_byte;
    n       = {1'b0, st.held_count} + 3'd1;
    new_len = lud_pkg::lead_len(text_byte);

    if (end_of_text) begin
      emit = 1'b1;
    end else if (st.held_count == 2'd0) begin
      emit = (new_len == 3'd1);
    end else begin
      emit = (n >= st.seq_len);
    end

    // greedy parse of the buffered bytes
    res   = '0;
    pos   = 3'd0;
    cnt   = 2'd0;
    l     = 3'd1;
    for (int k = 0; k < 4; k++) begin
      if (emit && (pos < n) && (cnt != 2'd3)) begin
        l = lud_pkg::lead_len(bytes[pos[1:0]]);
        if ((l > 3'd1) && ((pos + l) <= n)) begin
          res.cps[cnt] = lud_pkg::decode_seq(bytes[pos[1:0]], bytes[pos[1:0] + 2'd1],
                                             bytes[pos[1:0] + 2'd2], bytes[pos[1:0] + 2'd3],
                                             l);
        end else begin
          res.cps[cnt] = {13'd0, bytes[pos[1:0]]};
          l = 3'd1;
        end
        cnt = cnt + 2'd1;
        pos = pos + l;
      end
    end
    res.count = cnt;
    res.last  = end_of_text;

    st_nxt = st;
    if (emit) begin
      st_nxt = '0;
    end else begin
      if (st.held_count == 2'd0) begin
        st_nxt.seq_len = new_len;
      end
      if (st.held_count != 2'd3) begin
        st_nxt.held_bytes[st.held_count] = text_byte;
        st_nxt.held_count = st.held_count + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/lenient_utf8_decoder.sv @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder
// Turns a byte string into code points, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one byte (in_text_byte) and a flag
// on the string's last byte (in_end_of_text).
// Output channel: out_valid / out_stall carry one code point
// (out_code_point) and a flag on the string's last code point
// (out_final_point).
// Lead bytes C0-DF, E0-EF and F0-FF open 2, 3 and 4 byte sequences; other
// bytes pass through raw. Continuation bytes are not checked.
// An item that completes a code point passes from the input register through
// the decode logic into the result register, which drives the output.
// Throughput: one byte per cycle while the input does not stall. A byte that
// yields k results holds the result register until all k are taken; only a
// truncated sequence at end of string yields more than one (up to three), so
// the input can stall there. Bytes that only extend an open sequence never stall.
// Reset clears the input register, the result register and any open sequence.
// When the receiver stalls, the current code point holds and the input stalls
// once the input register holds a byte that yields a code point while the
// result register cannot empty.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic        out_final_point
);

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_end_r;
  lud_pkg::lud_state_t state_r;
  lud_pkg::lud_state_t state_nxt;
  lud_pkg::lud_res_t   res;
  logic [2:0][20:0]    cps_r;
  logic [1:0]          cnt_r;
  logic                fin_r;
  logic                take;
  logic                free;
  logic                s1_move;
  logic                accept;

  lud_decode u_decode (
    .st          (state_r),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_end_r),
    .st_nxt      (state_nxt),
    .res         (res)
  );

  always_comb begin
    take     = (cnt_r != 2'd0) && !out_stall;
    free     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);
    s1_move  = s1_valid_r && (free || (res.count == 2'd0));
    in_stall = s1_valid_r && !s1_move;
    accept   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
      state_r    <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
      if (s1_move && (res.count != 2'd0)) begin
        cnt_r <= res.count;
      end else if (take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_end_of_text;
    end
    if (s1_move && (res.count != 2'd0)) begin
      cps_r <= res.cps;
      fin_r <= res.last;
    end else if (take) begin
      cps_r[0] <= cps_r[1];
      cps_r[1] <= cps_r[2];
    end
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_code_point  = cps_r[0];
  assign out_final_point = fin_r && (cnt_r == 2'd1);

endmodule

@@ rtl/core/lud_checker.sv @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "lenient_utf8_decoder_assert.svh"

module lud_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_text_byte,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_code_point,
  input logic        out_final_point
);

  `LUD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out_valid dropped")
  `LUD_ASSERT(a_out_stable, clk, rst_n,
              out_valid && out_stall |=> $stable({out_code_point, out_final_point}),
              "stalled item changed")
  `LUD_ASSERT(a_in_hold, clk, rst_n,
              in_valid && in_stall |=> in_valid && $stable({in_text_byte, in_end_of_text}),
              "stalled input item changed")
  `LUD_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid, "input stalled with empty output")
  `LUD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall,
                     "output not empty after reset")

endmodule

bind lenient_utf8_decoder lud_checker u_lud_checker (.*);

@@ dv/lenient_utf8_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder testbench
// Drives byte strings into the decoder and checks each code point against a
// predictor that tracks the open sequence. A directed set covers the lead
// byte limits, raw bytes and strings cut short; random strings follow under
// several sender and receiver idle mixes, including one long receiver hold.
// ----------------------------------------------------------------------------

typedef struct {
  logic [20:0] cp;
  logic        fin;
} code_point_t;

class utf8_point_board;
  code_point_t pending_points[$];
  logic [7:0]  open_bytes[3];
  int unsigned open_cnt;
  int unsigned open_len;
  int unsigned errors;

  function new();
    open_bytes = '{8'h00, 8'h00, 8'h00};
    open_cnt   = 0;
    open_len   = 0;
    errors     = 0;
  endfunction

  function int unsigned span_of(logic [7:0] b);
    if (b < 8'hC0) return 1;
    if (b < 8'hE0) return 2;
    if (b < 8'hF0) return 3;
    return 4;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function int unsigned outstanding();
    return pending_points.size();
  endfunction

  // predict the code points released by one accepted item
  function void take_byte(logic [7:0] b, logic e);
    logic [7:0]  seq[4];
    logic [31:0] acc;
    int unsigned n, i, k, l;
    bit          flush;
    code_point_t pt;
    for (i = 0; i < 4; i++) seq[i] = 8'h00;
    for (i = 0; i < open_cnt; i++) seq[i] = open_bytes[i];
    seq[open_cnt] = b;
    n = open_cnt + 1;
    if (e) flush = 1'b1;
    else if (open_cnt == 0) flush = (span_of(b) == 1);
    else flush = (n >= open_len);
    if (!flush) begin
      if (open_cnt == 0) open_len = span_of(b);
      if (open_cnt < 3) begin
        open_bytes[open_cnt] = b;
        open_cnt++;
      end
      return;
    end
    i = 0;
    while (i < n) begin
      l = span_of(seq[i]);
      if (l > 1 && i + l <= n) begin
        case (l)
          2: acc = {24'd0, seq[i] & 8'h1F};
          3: acc = {24'd0, seq[i] & 8'h0F};
          default: acc = {24'd0, seq[i] & 8'h07};
        endcase
        for (k = 1; k < l; k++) acc = (acc << 6) | {26'd0, seq[i+k][5:0]};
      end else begin
        acc = {24'd0, seq[i]};
        l = 1;
      end
      pt.cp  = acc[20:0];
      pt.fin = e && (i + l == n);
      pending_points.insert(pending_points.size(), pt);
      i += l;
    end
    open_bytes = '{8'h00, 8'h00, 8'h00};
    open_cnt   = 0;
    open_len   = 0;
  endfunction

  task match_point(logic [20:0] cp, logic fin);
    code_point_t want;
    if (pending_points.size() == 0) begin
      report($sformatf("code point %06h with nothing expected", cp));
      return;
    end
    want = pending_points[0];
    pending_points.delete(0);
    if (cp !== want.cp)
      report($sformatf("code point got %06h want %06h", cp, want.cp));
    if (fin !== want.fin)
      report($sformatf("final flag got %0b want %0b (cp %06h)", fin, want.fin, want.cp));
  endtask
endclass

module lenient_utf8_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] out_code_point;
  logic        out_final_point;

  utf8_point_board board = new();

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  logic [7:0]  text_q[$];

  lenient_utf8_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_final_point(out_final_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[lenient_utf8_decoder] ERROR");
      $finish;
    end
  end

  // receiver: random stall, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_point(out_code_point, out_final_point);
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b, e);
    sent++;
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic void append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic [7:0] trail_byte();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // mostly well-formed sequences, some noise, last sequence sometimes cut
  task automatic send_random_text();
    int unsigned units, u, k, len, j, last_len;
    units = $urandom_range(1, 6);
    last_len = 1;
    for (u = 0; u < units; u++) begin
      k = $urandom_range(9);
      len = 1;
      case (k)
        0, 1, 2: append_byte(8'($urandom_range(8'h7F)));
        3:       append_byte(8'($urandom_range(8'h80, 8'hBF)));
        4, 5: begin
          append_byte(8'($urandom_range(8'hC0, 8'hDF)));
          len = 2;
        end
        6, 7: begin
          append_byte(8'($urandom_range(8'hE0, 8'hEF)));
          len = 3;
        end
        8: begin
          append_byte(8'($urandom_range(8'hF0, 8'hFF)));
          len = 4;
        end
        default: append_byte(8'($urandom_range(255)));
      endcase
      for (j = 1; j < len; j++) append_byte(trail_byte());
      last_len = len;
    end
    if (last_len > 1 && $urandom_range(3) == 0) begin
      k = $urandom_range(1, last_len - 1);
      for (j = 0; j < k; j++) void'(text_q.pop_back());
    end
    send_text();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items);
    int unsigned target;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    target = sent + n_items;
    while (sent < target) send_random_text();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // raw bytes and continuation bytes as leads
    text_q = '{8'h00, 8'h7F, 8'h80, 8'hBF};
    send_text();
    // full 2, 3 and 4 byte sequences at the lead limits
    text_q = '{8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hFF, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    // lead byte as the whole string
    text_q = '{8'hDF};
    send_text();
    // strings cut short inside a sequence
    text_q = '{8'hE0, 8'h80};
    send_text();
    text_q = '{8'hF0, 8'hC3, 8'hA9};
    send_text();
    text_q = '{8'hF7, 8'hE0, 8'h80};
    send_text();
    drain();

    run_phase(0, 0, 100);
    run_phase(67, 0, 90);
    run_phase(0, 67, 90);
    run_phase(19, 19, 90);

    // long receiver hold while the sender keeps offering items
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 200;
    run_phase(0, 0, 40);
    run_phase(40, 40, 40);

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("[lenient_utf8_decoder] OK");
    end else begin
      $display("[lenient_utf8_decoder] ERROR");
    end
    $finish;
  end

endmodule
